/* src/assert_macros.svh */
// assertion macros for the vertex deduplicator rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tvd_pkg.sv */
// shared types, constants and float compare helpers for the vertex deduplicator
// no dependencies
package tvd_pkg;

  localparam int MAX_VERTICES = 2048;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int OUT_IDX_W    = 11;
  localparam int OUT_CNT_W    = 12;
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vertex_t;

  typedef vertex_t [2:0] tri_t;

  typedef struct packed {
    logic        new_model;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] c_x;
    logic [31:0] c_y;
    logic [31:0] c_z;
  } tvd_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index_a;
    logic [OUT_IDX_W-1:0] index_b;
    logic [OUT_IDX_W-1:0] index_c;
    logic                 is_degenerate;
    logic [OUT_CNT_W-1:0] unique_count;
    logic [OUT_CNT_W-1:0] degenerate_total;
    logic                 table_overflow;
  } tvd_out_t;

  // top level -> search engine
  typedef struct packed {
    logic start;
    logic clear;
    logic take;
  } tvd_ctrl_t;

  // search engine -> top level
  typedef struct packed {
    logic             idle;
    logic             done;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic             ovf;
    logic [CNT_W-1:0] vcount;
  } tvd_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } tvd_state_t;

  typedef enum logic [1:0] {
    CORNER_A,
    CORNER_B,
    CORNER_C
  } tvd_corner_t;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic coord_eq(input logic [31:0] a, input logic [31:0] b);
    logic eq;
    if (is_nan(a) || is_nan(b)) eq = 1'b0;
    else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) eq = 1'b1;
    else eq = (a == b);
    return eq;
  endfunction

  function automatic logic vert_eq(input vertex_t p, input vertex_t q);
    return coord_eq(p.x, q.x) && coord_eq(p.y, q.y) && coord_eq(p.z, q.z);
  endfunction

  // low bits of a table index as carried on the result channel
  function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W+OUT_IDX_W-1:0] t;
    t = {{OUT_IDX_W{1'b0}}, i};
    return t[OUT_IDX_W-1:0];
  endfunction

  // vertex count saturated to the result field width
  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] t;
    logic [OUT_CNT_W-1:0]       r;
    t = {{OUT_CNT_W{1'b0}}, c};
    if (t > (CNT_W + OUT_CNT_W)'(OUT_CNT_MAX)) r = OUT_CNT_MAX;
    else r = t[OUT_CNT_W-1:0];
    return r;
  endfunction

endpackage

/* src/tvd_vertex_ram.sv */
// single-port-write, single-port-read vertex memory with registered read data
// depends on tvd_pkg
module tvd_vertex_ram (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [tvd_pkg::IDX_W-1:0] wr_addr,
  input  tvd_pkg::vertex_t        wr_data,
  input  logic                    rd_en,
  input  logic [tvd_pkg::IDX_W-1:0] rd_addr,
  output tvd_pkg::vertex_t        rd_data
);
  import tvd_pkg::*;

  vertex_t mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/tvd_search_engine.sv */
// linear search / append engine over the vertex memory, one entry per cycle
// depends on tvd_pkg and tvd_vertex_ram
module tvd_search_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  tvd_pkg::tvd_ctrl_t ctrl,
  input  tvd_pkg::tri_t      corners,
  output tvd_pkg::tvd_stat_t stat
);
  import tvd_pkg::*;

  tvd_state_t       state_r, state_nxt;
  tvd_corner_t      corner_r, corner_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0] vcount_r, vcount_nxt;
  logic [IDX_W-1:0] idx_r [3];
  logic [IDX_W-1:0] idx_nxt [3];
  logic             ovf_r, ovf_nxt;

  logic             rd_en, wr_en;
  vertex_t          rd_data, cur;
  logic             hit, more, last_corner;

  tvd_vertex_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (vcount_r[IDX_W-1:0]),
    .wr_data (cur),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (corner_r)
      CORNER_A: cur = corners[0];
      CORNER_B: cur = corners[1];
      CORNER_C: cur = corners[2];
      default:  cur = corners[0];
    endcase
  end

  assign hit         = pend_r && vert_eq(rd_data, cur);
  assign more        = (issue_r < vcount_r);
  assign last_corner = (corner_r == CORNER_C);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.start) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if ((hit || !more) && last_corner) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (ctrl.take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    corner_nxt    = corner_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    vcount_nxt    = vcount_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          corner_nxt = CORNER_A;
          issue_nxt  = '0;
          ovf_nxt    = 1'b0;
          if (ctrl.clear) vcount_nxt = '0;
        end
      end
      ST_SEARCH: begin
        priority if (hit) begin
          idx_nxt[corner_r] = pend_addr_r;
        end else if (more) begin
          // read the next stored entry, compare it next cycle
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = issue_r[IDX_W-1:0];
          issue_nxt     = issue_r + CNT_W'(1);
        end else if (vcount_r == CNT_W'(MAX_VERTICES)) begin
          ovf_nxt           = 1'b1;
          idx_nxt[corner_r] = '0;
        end else begin
          // append; later corners see it through the memory
          wr_en             = 1'b1;
          idx_nxt[corner_r] = vcount_r[IDX_W-1:0];
          vcount_nxt        = vcount_r + CNT_W'(1);
        end
        if (hit || !more) begin
          issue_nxt = '0;
          if (!last_corner) corner_nxt = tvd_corner_t'(corner_r + 2'd1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= '0;
      pend_r   <= 1'b0;
      corner_r <= CORNER_A;
      issue_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vcount_r <= vcount_nxt;
      pend_r   <= pend_nxt;
      corner_r <= corner_nxt;
      issue_r  <= issue_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    idx_r       <= idx_nxt;
  end

  assign stat.idle   = (state_r == ST_IDLE);
  assign stat.done   = (state_r == ST_DONE);
  assign stat.idx_a  = idx_r[0];
  assign stat.idx_b  = idx_r[1];
  assign stat.idx_c  = idx_r[2];
  assign stat.ovf    = ovf_r;
  assign stat.vcount = vcount_r;

endmodule

/* src/triangle_vertex_deduplicator.sv */
// top level of the triangle vertex deduplicator: handshakes, degeneracy check,
// degenerate count and output register; depends on tvd_pkg, tvd_search_engine
//
//   channel  dir  ports                          one beat
//   in       in   in_valid in_ready in_data      one triangle (three corners)
//   out      out  out_valid out_ready out_data   indices, counts, flags
//
// one triangle at a time; for each corner the single memory read port scans the
// stored vertices, one stored vertex per cycle, until it finds a match or
// reaches the end of the table
// reset clears the vertex count, degenerate count and handshakes; the memory
// keeps no per-entry state and needs no clearing pass
// a finished result waits in the output register while the next triangle is
// accepted; the engine holds its result only while that register is full
`include "assert_macros.svh"

module triangle_vertex_deduplicator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tvd_pkg::tvd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tvd_pkg::tvd_out_t out_data
);
  import tvd_pkg::*;

  tri_t                 tri_r;
  tri_t                 in_tri;
  logic                 degen_r;
  logic [OUT_CNT_W-1:0] deg_cnt_r, deg_cnt_nxt, deg_base;
  logic                 in_degen;
  logic                 in_beat, load_out;
  logic                 out_valid_r;
  tvd_out_t             out_data_r;
  tvd_ctrl_t            ctrl;
  tvd_stat_t            stat;

  // accept only while the engine is free
  assign in_ready = stat.idle;
  assign in_beat  = in_valid && in_ready;

  assign in_tri[0] = '{x: in_data.a_x, y: in_data.a_y, z: in_data.a_z};
  assign in_tri[1] = '{x: in_data.b_x, y: in_data.b_y, z: in_data.b_z};
  assign in_tri[2] = '{x: in_data.c_x, y: in_data.c_y, z: in_data.c_z};

  // degeneracy is decided on the incoming beat, before any search
  assign in_degen = vert_eq(in_tri[0], in_tri[1]) || vert_eq(in_tri[1], in_tri[2]) ||
                    vert_eq(in_tri[2], in_tri[0]);

  // new model restarts the degenerate count, which saturates
  assign deg_base    = in_data.new_model ? '0 : deg_cnt_r;
  assign deg_cnt_nxt = (in_degen && (deg_base != OUT_CNT_MAX)) ?
                       deg_base + OUT_CNT_W'(1) : deg_base;

  // result moves to the output register once it is empty or being drained
  assign load_out = stat.done && (!out_valid_r || out_ready);

  assign ctrl.start = in_beat;
  assign ctrl.clear = in_data.new_model;
  assign ctrl.take  = load_out;

  tvd_search_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .corners (tri_r),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) deg_cnt_r <= deg_cnt_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      tri_r   <= in_tri;
      degen_r <= in_degen;
    end
    if (load_out) begin
      out_data_r.index_a          <= out_idx(stat.idx_a);
      out_data_r.index_b          <= out_idx(stat.idx_b);
      out_data_r.index_c          <= out_idx(stat.idx_c);
      out_data_r.is_degenerate    <= degen_r;
      out_data_r.unique_count     <= sat_cnt(stat.vcount);
      out_data_r.degenerate_total <= deg_cnt_r;
      out_data_r.table_overflow   <= stat.ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a triangle always leaves at least one vertex stored
  `TVD_ASSERT_NOW(a_count_nonzero, out_valid_r, out_data_r.unique_count != '0, "empty table on result")
  // a degenerate result implies a nonzero degenerate count
  `TVD_ASSERT_NOW(a_degen_counted, out_valid_r && out_data_r.is_degenerate, out_data_r.degenerate_total != '0, "degenerate not counted")
  // accepted triangle keeps the input side closed next cycle
  `TVD_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready, "input open while searching")
  // finished result is never lost: it waits until the output register takes it
  `TVD_ASSERT_NEXT(a_result_held, stat.done && !load_out, stat.done, "pending result dropped")

endmodule

/* dv/triangle_vertex_deduplicator_tb.sv */
// self-checking testbench for triangle_vertex_deduplicator: random and directed triangles
// against a built-in dedup table; depends on tvd_pkg and the triangle_vertex_deduplicator rtl
module triangle_vertex_deduplicator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvd_pkg::*;

  // run shape
  localparam int RANDOM_TRIANGLES = 72;
  localparam int LAST_TRIANGLES   = 12;
  localparam int DRAIN_CYCLES     = 1000;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned DEGEN_CAP = 4095;
  localparam int unsigned COUNT_CAP = 4095;

  // interesting float bit patterns
  localparam logic [31:0] F_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_SNAN     = 32'h7F80_0001;
  localparam logic [31:0] F_ALL_ONES = 32'hFFFF_FFFF;  // a nan too
  localparam logic [31:0] F_MAX_POS  = 32'h7FFF_FFFF;  // largest pattern below sign, nan
  localparam logic [31:0] F_MAX_FIN  = 32'h7F7F_FFFF;
  localparam logic [31:0] F_MIN_SUB  = 32'h0000_0001;
  localparam logic [31:0] F_NEG_SUB  = 32'h8000_0001;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  tvd_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tvd_out_t  out_data;

  triangle_vertex_deduplicator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // dedup table kept by the testbench, updated on every accepted triangle
  // ---------------------------------------------------------------------------
  vertex_t     vertex_store [MAX_VERTICES];
  int unsigned stored_count = 0;
  int unsigned degen_count  = 0;

  tvd_in_t     triangles_to_send [$];  // stimulus not yet offered
  tvd_out_t    dedup_due [$];          // predicted results, oldest first

  int          mismatches  = 0;
  int          out_beats   = 0;
  int          cycle_count = 0;
  bit          idling_on   = 1'b1;
  bit          in_taken    = 1'b0;     // in beat accepted at the last rising edge
  int          in_gap      = 0;
  int          out_gap     = 0;

  // float equality: nan never equal, signed zeros equal, otherwise bitwise
  function automatic bit coord_same(input logic [31:0] p, input logic [31:0] q);
    bit p_nan;
    bit q_nan;
    p_nan = (&p[30:23]) && (|p[22:0]);
    q_nan = (&q[30:23]) && (|q[22:0]);
    if (p_nan || q_nan) return 1'b0;
    if (p[30:0] == 31'd0 && q[30:0] == 31'd0) return 1'b1;
    return p == q;
  endfunction

  function automatic bit corner_same(input vertex_t p, input vertex_t q);
    return coord_same(p.x, q.x) && coord_same(p.y, q.y) && coord_same(p.z, q.z);
  endfunction

  // oldest match wins; a miss appends unless the table is full
  function automatic int unsigned find_or_store(input vertex_t v, inout bit spilled);
    for (int unsigned k = 0; k < stored_count; k++)
      if (corner_same(v, vertex_store[k])) return k;
    if (stored_count >= MAX_VERTICES) begin
      spilled = 1'b1;
      return 0;
    end
    vertex_store[stored_count] = v;
    stored_count++;
    return stored_count - 1;
  endfunction

  function automatic tvd_out_t dedup_triangle(input tvd_in_t t);
    vertex_t     c [3];
    int unsigned k [3];
    bit          spilled;
    bit          degen;
    tvd_out_t    r;
    if (t.new_model) begin
      stored_count = 0;
      degen_count  = 0;
    end
    c[0] = {t.a_x, t.a_y, t.a_z};
    c[1] = {t.b_x, t.b_y, t.b_z};
    c[2] = {t.c_x, t.c_y, t.c_z};
    // degeneracy looks at the raw corners, before any table update
    degen = corner_same(c[0], c[1]) || corner_same(c[1], c[2]) || corner_same(c[2], c[0]);
    if (degen && degen_count < DEGEN_CAP) degen_count++;
    spilled = 1'b0;
    for (int i = 0; i < 3; i++) k[i] = find_or_store(c[i], spilled);
    r.index_a          = OUT_IDX_W'(k[0]);
    r.index_b          = OUT_IDX_W'(k[1]);
    r.index_c          = OUT_IDX_W'(k[2]);
    r.is_degenerate    = degen;
    r.unique_count     = (stored_count > COUNT_CAP) ? OUT_CNT_W'(COUNT_CAP)
                                                    : OUT_CNT_W'(stored_count);
    r.degenerate_total = OUT_CNT_W'(degen_count);
    r.table_overflow   = spilled;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string what);
    $display("result beat %0d: %s", out_beats, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic vertex_t mkv(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z);
    return {x, y, z};
  endfunction

  function automatic void queue_tri(input bit fresh_model, input vertex_t a,
                                    input vertex_t b, input vertex_t c);
    tvd_in_t t;
    t.new_model           = fresh_model;
    {t.a_x, t.a_y, t.a_z} = a;
    {t.b_x, t.b_y, t.b_z} = b;
    {t.c_x, t.c_y, t.c_z} = c;
    triangles_to_send.push_back(t);
  endfunction

  // never a nan, exponent below all-ones
  function automatic logic [31:0] finite_coord();
    return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 254)), 23'($urandom)};
  endfunction

  // unique by construction: the number sits in the x mantissa, x is never zero
  function automatic vertex_t numbered_vertex(input int unsigned num);
    vertex_t v;
    v.x = {1'($urandom_range(0, 1)), 8'($urandom_range(1, 254)), 23'(num)};
    v.y = finite_coord();
    v.z = finite_coord();
    return v;
  endfunction

  function automatic logic [31:0] odd_coord();
    case ($urandom_range(0, 11))
      0:       return F_POS_ZERO;
      1:       return F_NEG_ZERO;
      2:       return F_POS_INF;
      3:       return F_NEG_INF;
      4:       return F_QNAN;
      5:       return F_SNAN;
      6:       return F_ALL_ONES;
      7:       return F_MAX_FIN;
      8:       return F_MIN_SUB;
      9:       return F_NEG_SUB;
      10:      return F_ONE;
      default: return $urandom;
    endcase
  endfunction

  // a zero may come back with the other sign, still the same vertex
  function automatic logic [31:0] flip_zero(input logic [31:0] v);
    if (v[30:0] == 31'd0 && $urandom_range(0, 1) == 1) return v ^ F_NEG_ZERO;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one triangle per beat, random gaps between beats
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_triangles
    logic    nxt_valid;
    tvd_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    // a beat still waiting keeps valid and payload as they are
    if (rst_n && (!in_valid || in_taken)) begin
      nxt_valid = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (triangles_to_send.size() != 0) begin
        if (idling_on && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(0, 12);  // idle gap before the next beat
        end else begin
          nxt_valid = 1'b1;
          nxt_data  = triangles_to_send.pop_front();
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin : drive_ready
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (out_gap != 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_gap   = $urandom_range(0, 12);
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted triangles, check every result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    tvd_out_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) dedup_due.push_back(dedup_triangle(in_data));
      if (out_valid && out_ready) begin
        if (dedup_due.size() == 0) begin
          log_mismatch("result with no triangle outstanding");
        end else begin
          want = dedup_due.pop_front();
          check_field("index_a", 32'(out_data.index_a), 32'(want.index_a));
          check_field("index_b", 32'(out_data.index_b), 32'(want.index_b));
          check_field("index_c", 32'(out_data.index_c), 32'(want.index_c));
          check_field("is_degenerate", 32'(out_data.is_degenerate),
                      32'(want.is_degenerate));
          check_field("unique_count", 32'(out_data.unique_count),
                      32'(want.unique_count));
          check_field("degenerate_total", 32'(out_data.degenerate_total),
                      32'(want.degenerate_total));
          check_field("table_overflow", 32'(out_data.table_overflow),
                      32'(want.table_overflow));
        end
        out_beats++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", dedup_due.size());
      $display("triangle_vertex_deduplicator_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    vertex_t     seen [$];     // vertices of the current model, for reuse
    vertex_t     filled [$];   // everything stored in the last part
    vertex_t     corner [3];
    vertex_t     v;
    bit          nm;
    int unsigned pick;
    int unsigned num;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: shapes, zeros, nans, infinities, extremes, clears
    queue_tri(1'b0, mkv(F_ONE, F_POS_ZERO, F_POS_ZERO), mkv(F_POS_ZERO, F_ONE, F_POS_ZERO),
              mkv(F_POS_ZERO, F_POS_ZERO, F_ONE));
    v = mkv(F_MAX_FIN, F_NEG_INF, F_MIN_SUB);
    queue_tri(1'b0, v, v, v);                                   // all three corners equal
    v = mkv(F_ONE, F_ONE, F_ONE);
    queue_tri(1'b0, v, v, mkv(F_NEG_SUB, F_ONE, F_ONE));       // a equals b
    queue_tri(1'b0, mkv(F_MIN_SUB, F_ONE, F_ONE), v, v);       // b equals c
    queue_tri(1'b0, mkv(F_POS_INF, F_ONE, F_ONE), v,
              mkv(F_POS_INF, F_ONE, F_ONE));                    // c equals a, appended this beat
    // signed zeros all match each other
    queue_tri(1'b0, mkv(F_POS_ZERO, F_POS_ZERO, F_POS_ZERO),
              mkv(F_NEG_ZERO, F_NEG_ZERO, F_NEG_ZERO), mkv(F_POS_ZERO, F_NEG_ZERO, F_POS_ZERO));
    // nan corners never match, not even themselves
    v = mkv(F_QNAN, F_QNAN, F_QNAN);
    queue_tri(1'b0, v, v, v);
    queue_tri(1'b0, mkv(F_ONE, F_SNAN, F_POS_ZERO), mkv(F_ONE, F_SNAN, F_POS_ZERO),
              mkv(F_ALL_ONES, F_ALL_ONES, F_ALL_ONES));
    // infinities by sign
    queue_tri(1'b0, mkv(F_POS_INF, F_POS_INF, F_POS_INF), mkv(F_NEG_INF, F_NEG_INF, F_NEG_INF),
              mkv(F_POS_INF, F_POS_INF, F_POS_INF));
    // bit extremes; the zero vertex is already stored
    queue_tri(1'b0, mkv(F_MAX_POS, F_MAX_POS, F_MAX_POS), mkv(F_NEG_ZERO, F_POS_ZERO, F_NEG_ZERO),
              mkv(F_NEG_SUB, F_MAX_FIN, F_NEG_INF));
    // old entries found again
    queue_tri(1'b0, mkv(F_ONE, F_ONE, F_ONE), mkv(F_ONE, F_POS_ZERO, F_NEG_ZERO),
              mkv(F_MAX_FIN, F_NEG_INF, F_MIN_SUB));
    // zeros of mixed sign per coordinate
    queue_tri(1'b0, mkv(F_NEG_ZERO, F_ONE, F_POS_ZERO), mkv(F_POS_ZERO, F_ONE, F_NEG_ZERO),
              mkv(F_MIN_SUB, F_ONE, F_POS_ZERO));
    queue_tri(1'b0, mkv($urandom, $urandom, $urandom), mkv($urandom, $urandom, $urandom),
              mkv($urandom, $urandom, $urandom));
    // clear: indices start over, known corners become new again
    queue_tri(1'b1, mkv(F_ONE, F_ONE, F_ONE), mkv(F_POS_ZERO, F_POS_ZERO, F_POS_ZERO),
              mkv(F_ONE, F_ONE, F_ONE));
    // clear right after a clear, degenerate count restarts at one
    queue_tri(1'b1, mkv(F_NEG_ZERO, F_NEG_ZERO, F_NEG_ZERO),
              mkv(F_POS_ZERO, F_POS_ZERO, F_POS_ZERO), mkv(F_QNAN, F_ONE, F_ONE));
    queue_tri(1'b0, mkv(F_ALL_ONES, F_POS_ZERO, F_ONE), mkv(F_NEG_SUB, F_NEG_SUB, F_NEG_SUB),
              mkv(F_POS_ZERO, F_POS_ZERO, F_NEG_ZERO));

    // --- random triangles, heavy on reuse so lookups hit as well as miss
    for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
      nm = ($urandom_range(0, 19) == 0);
      if (nm) seen.delete();
      for (int c = 0; c < 3; c++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3 && seen.size() > 0) begin
          v = seen[$urandom_range(0, seen.size() - 1)];
          v = {flip_zero(v.x), flip_zero(v.y), flip_zero(v.z)};
        end else if (pick < 5 && c > 0) begin
          v = corner[$urandom_range(0, c - 1)];
        end else if (pick < 7) begin
          v = {odd_coord(), odd_coord(), odd_coord()};
        end else begin
          v = {$urandom, $urandom, $urandom};
        end
        corner[c] = v;
        seen.push_back(v);
      end
      queue_tri(nm, corner[0], corner[1], corner[2]);
    end
    while (triangles_to_send.size() != 0) @(posedge clk);

    // --- last part, no idling: fresh model back to back, some vertices found again
    idling_on = 1'b0;
    num = 0;
    for (int n = 0; n < LAST_TRIANGLES; n++) begin
      for (int c = 0; c < 3; c++) begin
        if (filled.size() > 0 && $urandom_range(0, 3) == 0) begin
          corner[c] = filled[$urandom_range(0, filled.size() - 1)];
        end else begin
          corner[c] = numbered_vertex(num);
          filled.push_back(corner[c]);
          num++;
        end
      end
      queue_tri(n == 0, corner[0], corner[1], corner[2]);
    end

    while (triangles_to_send.size() != 0 || in_valid || dedup_due.size() != 0)
      @(posedge clk);
    // room for anything the block might still emit
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && dedup_due.size() == 0) begin
      $display("triangle_vertex_deduplicator_tb passed");
    end else begin
      $display("triangle_vertex_deduplicator_tb failed");
    end
    $finish;
  end

endmodule

/* triangle_vertex_deduplicator.f */
+incdir+src
src/tvd_pkg.sv
src/tvd_vertex_ram.sv
src/tvd_search_engine.sv
src/triangle_vertex_deduplicator.sv
dv/triangle_vertex_deduplicator_tb.sv
